// ===== sv/qnl_pkg.sv =====
// package: types and constants for quaternion nlerp
`timescale 1ns / 1ps
`default_nettype none
package qnl_pkg;

  localparam int COMP_W     = 16;
  localparam int BLEND_W    = 17;
  localparam int SQRT_STEPS = 32;
  localparam int QUO_BITS   = 17;
  localparam int LAT        = 61;

  localparam logic [BLEND_W-1:0] ONE_Q16    = 17'd65536;
  localparam logic [31:0]        HALF_LIMIT = 32'd1073741824;

  typedef struct packed {
    logic signed [COMP_W-1:0] left_x;
    logic signed [COMP_W-1:0] left_y;
    logic signed [COMP_W-1:0] left_z;
    logic signed [COMP_W-1:0] left_w;
    logic signed [COMP_W-1:0] right_x;
    logic signed [COMP_W-1:0] right_y;
    logic signed [COMP_W-1:0] right_z;
    logic signed [COMP_W-1:0] right_w;
    logic [BLEND_W-1:0]       blend;
  } in_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] out_x;
    logic signed [COMP_W-1:0] out_y;
    logic signed [COMP_W-1:0] out_z;
    logic signed [COMP_W-1:0] out_w;
    logic                     degenerate;
  } out_t;

endpackage
`default_nettype wire

// ===== sv/qnl_if.sv =====
// interfaces: input and result channels
`timescale 1ns / 1ps
`default_nettype none
interface qnl_in_if;
  logic          valid;
  logic          ready;
  qnl_pkg::in_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface qnl_out_if;
  logic          valid;
  logic          ready;
  qnl_pkg::out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/quaternion_nlerp.sv =====
// top level: pipelined normalized quaternion lerp along the shortest path
// one item per cycle sustained while the output is not held by out_ch.ready
// stages: dot product, blend multiplies, normalize, squares, 32 square root
// steps, 17 restoring division steps, saturation; the whole pipe stalls together
// synchronous active-high reset clears all valid bits; payload is not reset
`timescale 1ns / 1ps
`default_nettype none
module quaternion_nlerp (
  input  wire logic  clk,
  input  wire logic  rst,
  qnl_in_if.sink     in_ch,
  qnl_out_if.source  out_ch
);

  logic en;
  logic v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, vo;

  logic signed [15:0] a1 [4];
  logic signed [15:0] b1 [4];
  logic signed [31:0] pr1 [4];
  logic [16:0] t1;

  logic signed [15:0] a2 [4];
  logic signed [16:0] bn2 [4];
  logic [16:0] t2, w2;

  logic signed [33:0] p3 [4];
  logic signed [33:0] q3 [4];
  logic signed [33:0] c4 [4];

  logic [31:0] mg5 [4];
  logic [3:0]  ng5, ng6, ng7, ng8, ng9, ng10;
  logic [31:0] mg6 [4];
  logic [31:0] mg7 [4];
  logic [31:0] m6;
  logic        dg6, dg7, dg8, dg9, dg10;
  logic        rt7;
  logic [4:0]  k7;
  logic [30:0] nm8 [4];
  logic [30:0] nm9 [4];
  logic [30:0] nm10 [4];
  logic [61:0] sq9 [4];
  logic [63:0] s10;

  logic [63:0] sq_s  [0:qnl_pkg::SQRT_STEPS];
  logic [63:0] sq_r  [0:qnl_pkg::SQRT_STEPS];
  logic [30:0] sq_nm [0:qnl_pkg::SQRT_STEPS][4];
  logic [3:0]  sq_ng [0:qnl_pkg::SQRT_STEPS];
  logic        sq_dg [0:qnl_pkg::SQRT_STEPS];
  logic        sq_v  [0:qnl_pkg::SQRT_STEPS];

  logic [49:0] dv_rem [0:qnl_pkg::QUO_BITS][4];
  logic [16:0] dv_q   [0:qnl_pkg::QUO_BITS][4];
  logic [49:0] dv_den [0:qnl_pkg::QUO_BITS];
  logic [3:0]  dv_ng  [0:qnl_pkg::QUO_BITS];
  logic        dv_dg  [0:qnl_pkg::QUO_BITS];
  logic        dv_v   [0:qnl_pkg::QUO_BITS];

  qnl_pkg::out_t res;

  assign en = !vo || out_ch.ready;
  assign in_ch.ready = en;

  // stage 1: component products for the dot product, blend clamp
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_ch.valid;
    end
    if (en) begin
      a1[0] <= in_ch.data.left_x;
      a1[1] <= in_ch.data.left_y;
      a1[2] <= in_ch.data.left_z;
      a1[3] <= in_ch.data.left_w;
      b1[0] <= in_ch.data.right_x;
      b1[1] <= in_ch.data.right_y;
      b1[2] <= in_ch.data.right_z;
      b1[3] <= in_ch.data.right_w;
      pr1[0] <= in_ch.data.left_x * in_ch.data.right_x;
      pr1[1] <= in_ch.data.left_y * in_ch.data.right_y;
      pr1[2] <= in_ch.data.left_z * in_ch.data.right_z;
      pr1[3] <= in_ch.data.left_w * in_ch.data.right_w;
      t1 <= (in_ch.data.blend > qnl_pkg::ONE_Q16) ? qnl_pkg::ONE_Q16 : in_ch.data.blend;
    end
  end

  // stage 2: shortest path sign
  always_ff @(posedge clk) begin
    logic signed [33:0] dot;
    dot = 34'(pr1[0]) + 34'(pr1[1]) + 34'(pr1[2]) + 34'(pr1[3]);
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        a2[i]  <= a1[i];
        bn2[i] <= dot[33] ? -17'(b1[i]) : 17'(b1[i]);
      end
      t2 <= t1;
      w2 <= qnl_pkg::ONE_Q16 - t1;
    end
  end

  // stage 3: blend products
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        p3[i] <= $signed({1'b0, w2}) * a2[i];
        q3[i] <= $signed({1'b0, t2}) * bn2[i];
      end
    end
  end

  // stage 4: blend sums
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        c4[i] <= p3[i] + q3[i];
      end
    end
  end

  // stage 5: sign and magnitude
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        ng5[i] <= c4[i][33];
        mg5[i] <= c4[i][33] ? 32'(-c4[i]) : 32'(c4[i]);
      end
    end
  end

  // stage 6: largest magnitude
  always_ff @(posedge clk) begin
    logic [31:0] m01, m23, mx;
    m01 = (mg5[0] > mg5[1]) ? mg5[0] : mg5[1];
    m23 = (mg5[2] > mg5[3]) ? mg5[2] : mg5[3];
    mx  = (m01 > m23) ? m01 : m23;
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
    if (en) begin
      mg6 <= mg5;
      ng6 <= ng5;
      m6  <= mx;
      dg6 <= (mx == 32'd0);
    end
  end

  // stage 7: normalize shift amount
  always_ff @(posedge clk) begin
    logic [4:0] lg;
    logic       pw;
    lg = 5'd0;
    for (int i = 0; i < 31; i++) begin
      if (m6[i]) lg = 5'(i);
    end
    pw = ((m6 & (m6 - 32'd1)) == 32'd0);
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
    if (en) begin
      mg7 <= mg6;
      ng7 <= ng6;
      dg7 <= dg6;
      rt7 <= (m6 > qnl_pkg::HALF_LIMIT);
      k7  <= pw ? (5'd30 - lg) : (5'd29 - lg);
    end
  end

  // stage 8: normalize
  always_ff @(posedge clk) begin
    logic [31:0] sh;
    if (rst) begin
      v8 <= 1'b0;
    end else if (en) begin
      v8 <= v7;
    end
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        sh = rt7 ? (mg7[i] >> 1) : (mg7[i] << k7);
        nm8[i] <= sh[30:0];
      end
      ng8 <= ng7;
      dg8 <= dg7;
    end
  end

  // stage 9: squares
  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (en) begin
      v9 <= v8;
    end
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        sq9[i] <= nm8[i] * nm8[i];
      end
      nm9 <= nm8;
      ng9 <= ng8;
      dg9 <= dg8;
    end
  end

  // stage 10: squared length
  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else if (en) begin
      v10 <= v9;
    end
    if (en) begin
      s10  <= 64'(sq9[0]) + 64'(sq9[1]) + 64'(sq9[2]) + 64'(sq9[3]);
      nm10 <= nm9;
      ng10 <= ng9;
      dg10 <= dg9;
    end
  end

  // square root, one result bit per stage
  always_comb begin
    sq_s[0]  = s10;
    sq_r[0]  = 64'd0;
    sq_nm[0] = nm10;
    sq_ng[0] = ng10;
    sq_dg[0] = dg10;
    sq_v[0]  = v10;
  end

  for (genvar j = 0; j < qnl_pkg::SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * j);
    logic [63:0] trial;
    assign trial = sq_r[j] + SQ_BIT;
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[j+1] <= 1'b0;
      end else if (en) begin
        sq_v[j+1] <= sq_v[j];
      end
      if (en) begin
        if (sq_s[j] >= trial) begin
          sq_s[j+1] <= sq_s[j] - trial;
          sq_r[j+1] <= (sq_r[j] >> 1) + SQ_BIT;
        end else begin
          sq_s[j+1] <= sq_s[j];
          sq_r[j+1] <= sq_r[j] >> 1;
        end
        sq_nm[j+1] <= sq_nm[j];
        sq_ng[j+1] <= sq_ng[j];
        sq_dg[j+1] <= sq_dg[j];
      end
    end
  end

  // division setup: numerator and doubled length
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= sq_v[qnl_pkg::SQRT_STEPS];
    end
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        dv_rem[0][i] <= {3'd0, sq_nm[qnl_pkg::SQRT_STEPS][i], 16'd0}
                        + sq_r[qnl_pkg::SQRT_STEPS][49:0];
        dv_q[0][i]   <= 17'd0;
      end
      dv_den[0] <= {sq_r[qnl_pkg::SQRT_STEPS][48:0], 1'b0};
      dv_ng[0]  <= sq_ng[qnl_pkg::SQRT_STEPS];
      dv_dg[0]  <= sq_dg[qnl_pkg::SQRT_STEPS];
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar j = 0; j < qnl_pkg::QUO_BITS; j++) begin : g_div
    localparam int QB = qnl_pkg::QUO_BITS - 1 - j;
    logic [49:0] dtr;
    assign dtr = dv_den[j] << QB;
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j+1] <= 1'b0;
      end else if (en) begin
        dv_v[j+1] <= dv_v[j];
      end
      if (en) begin
        for (int i = 0; i < 4; i++) begin
          if (dv_rem[j][i] >= dtr) begin
            dv_rem[j+1][i] <= dv_rem[j][i] - dtr;
            dv_q[j+1][i]   <= dv_q[j][i] | (17'd1 << QB);
          end else begin
            dv_rem[j+1][i] <= dv_rem[j][i];
            dv_q[j+1][i]   <= dv_q[j][i];
          end
        end
        dv_den[j+1] <= dv_den[j];
        dv_ng[j+1]  <= dv_ng[j];
        dv_dg[j+1]  <= dv_dg[j];
      end
    end
  end

  // saturation and output register
  always_ff @(posedge clk) begin
    logic [16:0] qv;
    logic signed [15:0] cv [4];
    for (int i = 0; i < 4; i++) begin
      qv = dv_q[qnl_pkg::QUO_BITS][i];
      if (dv_dg[qnl_pkg::QUO_BITS]) begin
        cv[i] = 16'sd0;
      end else if (dv_ng[qnl_pkg::QUO_BITS][i]) begin
        cv[i] = (qv > 17'd32768) ? -16'sd32768 : 16'(-qv);
      end else begin
        cv[i] = (qv > 17'd32767) ? 16'sd32767 : 16'(qv);
      end
    end
    if (rst) begin
      vo <= 1'b0;
    end else if (en) begin
      vo <= dv_v[qnl_pkg::QUO_BITS];
    end
    if (en) begin
      res.out_x      <= cv[0];
      res.out_y      <= cv[1];
      res.out_z      <= cv[2];
      res.out_w      <= cv[3];
      res.degenerate <= dv_dg[qnl_pkg::QUO_BITS];
    end
  end

  assign out_ch.valid = vo;
  assign out_ch.data  = res;

endmodule
`default_nettype wire
